### rtl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge of clk_i while rst_ni is high
`define ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on every rising edge of clk_i, also during reset
`define ASSERT_ANY(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### rtl/pef_pkg.sv
package pef_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;

  localparam int COL_W = 10;
  localparam int ROW_W = 12;
  localparam int CHAN_W = 8;

  localparam int CFG_IDX_W    = 8;
  localparam int CFG_DATA_W   = 16;
  localparam int CFG_WIDTH_W  = 11;
  localparam int CFG_HEIGHT_W = 13;

  localparam int IMAGE_WIDTH_RST  = 640;
  localparam int IMAGE_HEIGHT_RST = 480;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef logic [COL_W-1:0]  col_t;
  typedef logic [ROW_W-1:0]  row_t;
  typedef logic [CHAN_W-1:0] chan_t;
  typedef logic [QPTR_W-1:0] qptr_t;
  typedef logic [QCNT_W-1:0] qcnt_t;

  localparam col_t  COL_LAST_RST = col_t'(IMAGE_WIDTH_RST - 1);
  localparam row_t  ROW_LAST_RST = row_t'(IMAGE_HEIGHT_RST - 1);
  localparam qcnt_t QDEPTH       = qcnt_t'(QUEUE_DEPTH);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 8'd0,
    REG_IMAGE_HEIGHT = 8'd1
  } cfg_reg_e;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
  } pixel_t;

  // one classified pixel travelling from front to back
  typedef struct packed {
    pixel_t pix;
    col_t   col;
    row_t   row;
    logic   border;
    logic   interior;
    logic   done;
  } item_t;

endpackage

### rtl/pef_intf.sv
interface pef_pix_if import pef_pkg::*; ();
  logic  valid;
  logic  ready;
  chan_t in_red;
  chan_t in_green;
  chan_t in_blue;

  modport source (output valid, output in_red, output in_green, output in_blue,
                  input ready);
  modport sink   (input valid, input in_red, input in_green, input in_blue,
                  output ready);
endinterface

interface pef_res_if import pef_pkg::*; ();
  logic  valid;
  logic  ready;
  col_t  out_col;
  row_t  out_row;
  chan_t out_red;
  chan_t out_green;
  chan_t out_blue;
  logic  frame_done;
  logic  run_last;

  modport source (output valid, output out_col, output out_row, output out_red,
                  output out_green, output out_blue, output frame_done,
                  output run_last, input ready);
  modport sink   (input valid, input out_col, input out_row, input out_red,
                  input out_green, input out_blue, input frame_done,
                  input run_last, output ready);
endinterface

interface pef_cfg_if import pef_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/pef_front.sv
`include "assert_macros.svh"

module pef_front import pef_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  pef_cfg_if.sink       cfg_i,
  pef_pix_if.sink       pix_i,
  output logic          push_valid_o,
  output item_t         push_item_o,
  input  logic          push_ready_i
);

  col_t col_q, col_d, col_last_q, col_last_d;
  row_t row_q, row_d, row_last_q, row_last_d;
  logic accept;
  logic at_col_last, at_row_last;

  function automatic col_t width_last(logic [CFG_WIDTH_W-1:0] w);
    col_t r;
    if (w == '0) begin
      r = '0;
    end else if (w > CFG_WIDTH_W'(MAX_WIDTH)) begin
      r = col_t'(MAX_WIDTH - 1);
    end else begin
      r = col_t'(w - 1'b1);
    end
    return r;
  endfunction

  function automatic row_t height_last(logic [CFG_HEIGHT_W-1:0] h);
    row_t r;
    if (h == '0) begin
      r = '0;
    end else if (h > CFG_HEIGHT_W'(MAX_HEIGHT)) begin
      r = row_t'(MAX_HEIGHT - 1);
    end else begin
      r = row_t'(h - 1'b1);
    end
    return r;
  endfunction

  assign cfg_i.ready  = 1'b1;
  assign pix_i.ready  = push_ready_i;
  assign push_valid_o = pix_i.valid;
  assign accept       = pix_i.valid & push_ready_i;

  assign at_col_last = (col_q == col_last_q);
  assign at_row_last = (row_q == row_last_q);

  always_comb begin
    push_item_o.pix.red   = pix_i.in_red;
    push_item_o.pix.green = pix_i.in_green;
    push_item_o.pix.blue  = pix_i.in_blue;
    push_item_o.col       = col_q;
    push_item_o.row       = row_q;
    push_item_o.border    = (col_q == '0) | (row_q == '0) | at_col_last | at_row_last;
    push_item_o.interior  = (col_q >= col_t'(2)) & (row_q >= row_t'(2));
    push_item_o.done      = at_col_last & at_row_last;
  end

  always_comb begin
    col_d      = col_q;
    row_d      = row_q;
    col_last_d = col_last_q;
    row_last_d = row_last_q;
    if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.index))
        REG_IMAGE_WIDTH: begin
          col_last_d = width_last(cfg_i.data[CFG_WIDTH_W-1:0]);
          col_d      = '0;
          row_d      = '0;
        end
        REG_IMAGE_HEIGHT: begin
          row_last_d = height_last(cfg_i.data[CFG_HEIGHT_W-1:0]);
          col_d      = '0;
          row_d      = '0;
        end
        default: ;
      endcase
    end else if (accept) begin
      if (at_col_last) begin
        col_d = '0;
        row_d = at_row_last ? '0 : row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      col_last_q <= COL_LAST_RST;
      row_last_q <= ROW_LAST_RST;
    end else begin
      col_q      <= col_d;
      row_q      <= row_d;
      col_last_q <= col_last_d;
      row_last_q <= row_last_d;
    end
  end

  `ASSERT_RST(a_pos_in_frame, (col_q <= col_last_q) && (row_q <= row_last_q), "position outside frame")

endmodule

### rtl/pef_queue.sv
`include "assert_macros.svh"

module pef_queue import pef_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_valid_i,
  input  item_t push_item_i,
  output logic  push_ready_o,
  output logic  pop_valid_o,
  output item_t pop_item_o,
  input  logic  pop_ready_i
);

  item_t slot_q [QUEUE_DEPTH];
  qptr_t wr_ptr_q, rd_ptr_q;
  qcnt_t count_q;
  logic  push, pop;

  assign push_ready_o = (count_q != QDEPTH);
  assign pop_valid_o  = (count_q != '0);
  assign pop_item_o   = slot_q[rd_ptr_q];
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_valid_o & pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      case ({push, pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: ;
      endcase
    end
  end

  `ASSERT_RST(a_count_bound, count_q <= QDEPTH, "queue count above depth")
  `ASSERT_RST(a_ptr_gap, (count_q == QDEPTH) || (qptr_t'(count_q) == qptr_t'(wr_ptr_q - rd_ptr_q)), "queue pointers disagree with count")

endmodule

### rtl/pef_back.sv
`include "assert_macros.svh"

module pef_back import pef_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      q_valid_i,
  input  item_t     q_item_i,
  output logic      q_ready_o,
  pef_res_if.source res_o
);

  typedef struct packed {
    pixel_t prev;
    pixel_t prev2;
  } line_word_t;

  typedef struct packed {
    col_t   col;
    row_t   row;
    pixel_t pix;
    logic   frame_done;
    logic   run_last;
  } result_t;

  line_word_t line_mem [MAX_WIDTH];
  line_word_t rd_q;

  item_t   b_item_q;
  logic    b_valid_q;
  logic    phase_q, phase_d;
  pixel_t  win_top_q [2];
  pixel_t  win_bot_q [2];
  result_t res_q, res_d;
  logic    res_valid_q, res_valid_d;

  logic    need_int, need_bor, has_emit, is_final;
  logic    out_free, emit, b_done, take;
  pixel_t  grad_pix;

  function automatic chan_t grad8(chan_t t0, chan_t t1, chan_t t2,
                                  chan_t b0, chan_t b1, chan_t b2);
    logic [CHAN_W+1:0]        st;
    logic [CHAN_W+1:0]        sb;
    logic signed [CHAN_W+2:0] d;
    chan_t                    r;
    st = {2'b00, t0} + {2'b00, t1} + {2'b00, t2};
    sb = {2'b00, b0} + {2'b00, b1} + {2'b00, b2};
    d  = $signed({1'b0, sb}) - $signed({1'b0, st});
    if (d < 0) begin
      r = '0;
    end else if (d > $signed((CHAN_W+3)'(255))) begin
      r = 8'hff;
    end else begin
      r = d[CHAN_W-1:0];
    end
    return r;
  endfunction

  assign grad_pix.red   = grad8(win_top_q[0].red, win_top_q[1].red, rd_q.prev2.red,
                                win_bot_q[0].red, win_bot_q[1].red, b_item_q.pix.red);
  assign grad_pix.green = grad8(win_top_q[0].green, win_top_q[1].green, rd_q.prev2.green,
                                win_bot_q[0].green, win_bot_q[1].green, b_item_q.pix.green);
  assign grad_pix.blue  = grad8(win_top_q[0].blue, win_top_q[1].blue, rd_q.prev2.blue,
                                win_bot_q[0].blue, win_bot_q[1].blue, b_item_q.pix.blue);

  // interior result goes first, border pass-through second
  assign need_int  = b_item_q.interior & ~phase_q;
  assign need_bor  = b_item_q.border;
  assign has_emit  = need_int | need_bor;
  assign is_final  = need_int ? ~b_item_q.border : 1'b1;
  assign out_free  = ~res_valid_q | res_o.ready;
  assign emit      = b_valid_q & has_emit & out_free;
  assign b_done    = b_valid_q & (~has_emit | (out_free & is_final));
  assign take      = ~b_valid_q | b_done;
  assign q_ready_o = take;

  always_comb begin
    if (need_int) begin
      res_d.col        = b_item_q.col - 1'b1;
      res_d.row        = b_item_q.row - 1'b1;
      res_d.pix        = grad_pix;
      res_d.frame_done = 1'b0;
      res_d.run_last   = ~b_item_q.border;
    end else begin
      res_d.col        = b_item_q.col;
      res_d.row        = b_item_q.row;
      res_d.pix        = b_item_q.pix;
      res_d.frame_done = b_item_q.done;
      res_d.run_last   = 1'b1;
    end
  end

  always_comb begin
    res_valid_d = res_valid_q;
    if (emit) begin
      res_valid_d = 1'b1;
    end else if (res_o.ready) begin
      res_valid_d = 1'b0;
    end
  end

  always_comb begin
    phase_d = phase_q;
    if (b_done) begin
      phase_d = 1'b0;
    end else if (emit & need_int) begin
      phase_d = 1'b1;
    end
  end

  // line store: read on pop, rewrite the entry when the item retires
  always_ff @(posedge clk_i) begin
    if (b_done) begin
      line_mem[b_item_q.col] <= '{prev: b_item_q.pix, prev2: rd_q.prev};
    end
    if (q_valid_i & take) begin
      rd_q <= line_mem[q_item_i.col];
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_valid_i & take) begin
      b_item_q <= q_item_i;
    end
    if (emit) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q   <= 1'b0;
      phase_q     <= 1'b0;
      res_valid_q <= 1'b0;
      win_top_q   <= '{default: '0};
      win_bot_q   <= '{default: '0};
    end else begin
      if (take) begin
        b_valid_q <= q_valid_i;
      end
      phase_q     <= phase_d;
      res_valid_q <= res_valid_d;
      if (b_done) begin
        win_top_q[0] <= win_top_q[1];
        win_top_q[1] <= rd_q.prev2;
        win_bot_q[0] <= win_bot_q[1];
        win_bot_q[1] <= b_item_q.pix;
      end
    end
  end

  assign res_o.valid      = res_valid_q;
  assign res_o.out_col    = res_q.col;
  assign res_o.out_row    = res_q.row;
  assign res_o.out_red    = res_q.pix.red;
  assign res_o.out_green  = res_q.pix.green;
  assign res_o.out_blue   = res_q.pix.blue;
  assign res_o.frame_done = res_q.frame_done;
  assign res_o.run_last   = res_q.run_last;

  `ASSERT_RST(a_phase_ok, phase_q |-> (b_valid_q && b_item_q.interior && b_item_q.border), "pending border without a two-result item")
  `ASSERT_RST(a_done_is_last, (res_valid_q && res_q.frame_done) |-> res_q.run_last, "frame end not on last result of its pixel")

endmodule

### rtl/prewitt_edge_filter_rgb.sv
// channel   dir  width of payload             role
// pix_i     in   3 x 8 (red, green, blue)     raster-order pixel stream
// res_o     out  10 + 12 + 3 x 8 + 1 + 1      tagged results, interior then border
// cfg_i     in   8 index + 16 data            image_width (0), image_height (1)
//
// sustains one pixel transfer per cycle while res_o.ready stays high and no
// pixel causes two results; a pixel's first result passes the queue slot, the
// registered line store read and the result register before it can transfer
// pixels that cause two results hold the result port for both results; the
// four-entry queue between classifier and filter takes up that slack
// no clearing pass after reset: line stores are only read where written
// earlier in the same frame; reset clears counters, windows and valid bits
// result stalls back up through the filter stage and queue to pix_i.ready

module prewitt_edge_filter_rgb import pef_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  pef_cfg_if.sink   cfg_i,
  pef_pix_if.sink   pix_i,
  pef_res_if.source res_o
);

  // front to queue
  logic  push_valid;
  logic  push_ready;
  item_t push_item;

  // queue to back
  logic  pop_valid;
  logic  pop_ready;
  item_t pop_item;

  // front: frame position, register file, border and interior classification
  pef_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_i),
    .pix_i        (pix_i),
    .push_valid_o (push_valid),
    .push_item_o  (push_item),
    .push_ready_i (push_ready)
  );

  // decoupling queue so a stalled result port does not stop the pixel side at once
  pef_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_item_i  (push_item),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_item_o   (pop_item),
    .pop_ready_i  (pop_ready)
  );

  // back: line store, top and bottom rows of the 3x3 window, gradient and result register
  pef_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (pop_valid),
    .q_item_i  (pop_item),
    .q_ready_o (pop_ready),
    .res_o     (res_o)
  );

endmodule

### sim/prewitt_result_checker.sv
`timescale 1ns / 100ps

module prewitt_result_checker import pef_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  pef_cfg_if   cfg_mon,
  pef_pix_if   pix_mon,
  pef_res_if   res_mon,
  output int   mismatch_cnt_o,
  output int   pending_o
);

  typedef struct packed {
    col_t   col;
    row_t   row;
    pixel_t pix;
    logic   done;
    logic   last;
  } edge_result_t;

  logic [CFG_WIDTH_W-1:0]  width_q;
  logic [CFG_HEIGHT_W-1:0] height_q;
  int unsigned             col_q;
  int unsigned             row_q;
  pixel_t                  row_above[MAX_WIDTH];
  pixel_t                  row_two_above[MAX_WIDTH];
  pixel_t                  upper_win[2];
  pixel_t                  lower_win[2];
  edge_result_t            awaited_results[$];
  int                      fail_cnt = 0;

  assign mismatch_cnt_o = fail_cnt;

  task automatic clear_filter_state();
    width_q  = CFG_WIDTH_W'(IMAGE_WIDTH_RST);
    height_q = CFG_HEIGHT_W'(IMAGE_HEIGHT_RST);
    col_q    = 0;
    row_q    = 0;
    for (int i = 0; i < MAX_WIDTH; i++) begin
      row_above[i]     = '0;
      row_two_above[i] = '0;
    end
    upper_win = '{default: '0};
    lower_win = '{default: '0};
    awaited_results.delete();
  endtask

  // lower three minus upper three, clamped to the channel range
  function automatic chan_t vertical_diff(input chan_t u0, input chan_t u1, input chan_t u2,
                                          input chan_t d0, input chan_t d1, input chan_t d2);
    int s;
    s = int'(d0) + int'(d1) + int'(d2) - int'(u0) - int'(u1) - int'(u2);
    if (s > 255) s = 255;
    if (s < 0) s = 0;
    return chan_t'(s);
  endfunction

  task automatic model_pixel_results(input pixel_t px);
    int unsigned  w;
    int unsigned  h;
    int unsigned  x;
    int unsigned  y;
    pixel_t       two_up;
    pixel_t       one_up;
    logic         on_border;
    edge_result_t r;
    w = (width_q == 0) ? 1 : ((width_q > MAX_WIDTH) ? MAX_WIDTH : width_q);
    h = (height_q == 0) ? 1 : ((height_q > MAX_HEIGHT) ? MAX_HEIGHT : height_q);
    x = (col_q >= w) ? w - 1 : col_q;
    y = (row_q >= h) ? h - 1 : row_q;

    two_up           = row_two_above[x];
    one_up           = row_above[x];
    row_two_above[x] = one_up;
    row_above[x]     = px;

    on_border = (x == 0) || (y == 0) || (x == w - 1) || (y == h - 1);

    // interior result for the centre one up and one left comes first
    if (x >= 2 && y >= 2) begin
      r.col       = col_t'(x - 1);
      r.row       = row_t'(y - 1);
      r.pix.red   = vertical_diff(upper_win[0].red, upper_win[1].red, two_up.red,
                                  lower_win[0].red, lower_win[1].red, px.red);
      r.pix.green = vertical_diff(upper_win[0].green, upper_win[1].green, two_up.green,
                                  lower_win[0].green, lower_win[1].green, px.green);
      r.pix.blue  = vertical_diff(upper_win[0].blue, upper_win[1].blue, two_up.blue,
                                  lower_win[0].blue, lower_win[1].blue, px.blue);
      r.done      = 1'b0;
      r.last      = !on_border;
      awaited_results.push_back(r);
    end
    if (on_border) begin
      r.col  = col_t'(x);
      r.row  = row_t'(y);
      r.pix  = px;
      r.done = (x == w - 1) && (y == h - 1);
      r.last = 1'b1;
      awaited_results.push_back(r);
    end

    upper_win[0] = upper_win[1];
    upper_win[1] = two_up;
    lower_win[0] = lower_win[1];
    lower_win[1] = px;

    x++;
    if (x >= w) begin
      x = 0;
      y++;
      if (y >= h) y = 0;
    end
    col_q = x;
    row_q = y;
  endtask

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, actual %0d", field, want, got);
      fail_cnt++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    edge_result_t want;
    if (!rst_ni) begin
      clear_filter_state();
      pending_o <= 0;
    end else begin
      if (res_mon.valid && res_mon.ready) begin
        if (awaited_results.size() == 0) begin
          $error("unexpected result at col %0d row %0d", res_mon.out_col, res_mon.out_row);
          fail_cnt++;
        end else begin
          want = awaited_results.pop_front();
          check_field("out_col", 32'(want.col), 32'(res_mon.out_col));
          check_field("out_row", 32'(want.row), 32'(res_mon.out_row));
          check_field("out_red", 32'(want.pix.red), 32'(res_mon.out_red));
          check_field("out_green", 32'(want.pix.green), 32'(res_mon.out_green));
          check_field("out_blue", 32'(want.pix.blue), 32'(res_mon.out_blue));
          check_field("frame_done", 32'(want.done), 32'(res_mon.frame_done));
          check_field("run_last", 32'(want.last), 32'(res_mon.run_last));
        end
      end
      if (pix_mon.valid && pix_mon.ready) begin
        model_pixel_results({pix_mon.in_red, pix_mon.in_green, pix_mon.in_blue});
      end
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          REG_IMAGE_WIDTH: begin
            width_q = cfg_mon.data[CFG_WIDTH_W-1:0];
            col_q   = 0;
            row_q   = 0;
          end
          REG_IMAGE_HEIGHT: begin
            height_q = cfg_mon.data[CFG_HEIGHT_W-1:0];
            col_q    = 0;
            row_q    = 0;
          end
          default: ;
        endcase
      end
      pending_o <= awaited_results.size();
    end
  end

endmodule

### sim/prewitt_edge_filter_rgb_tb.sv
`timescale 1ns / 100ps

module prewitt_edge_filter_rgb_tb;
  import pef_pkg::*;

  // worst case is far below this: ~1.3k pixels, each with a full send gap and
  // two results that both wait out the longest stall, plus the pauses
  localparam int unsigned CYCLE_LIMIT  = 1_500_000;
  localparam int          RANDOM_ITEMS = 150;
  // quiet tail with no idling on either side
  localparam int          QUIET_ITEMS  = 50;
  // pixels that produce no result may still be in the pipe when the last
  // expected result shows up
  localparam int          SETTLE_CYCLES = 8;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  pef_cfg_if cfg_bus ();
  pef_pix_if pix_bus ();
  pef_res_if res_bus ();

  int          mismatch_cnt;
  int          pending_cnt;
  int unsigned cycle_cnt    = 0;
  int          send_odds    = 0;  // 0 disables sender gaps, else 1-in-n per pixel
  int          stall_odds   = 0;  // 0 disables receiver stalls, else 1-in-n per cycle
  int          stall_left   = 0;
  int          random_items = 0;

  prewitt_edge_filter_rgb dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_bus),
    .pix_i  (pix_bus),
    .res_o  (res_bus)
  );

  prewitt_result_checker checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_mon        (cfg_bus),
    .pix_mon        (pix_bus),
    .res_mon        (res_bus),
    .mismatch_cnt_o (mismatch_cnt),
    .pending_o      (pending_cnt)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // run limit, in case the block hangs or drops results
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // result side back-pressure: random bursts with ready low
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      res_bus.ready <= 1'b0;
    end else if (stall_left > 0) begin
      res_bus.ready <= 1'b0;
      stall_left    <= stall_left - 1;
    end else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
      res_bus.ready <= 1'b0;
      stall_left    <= $urandom_range(0, 10);
    end else begin
      res_bus.ready <= 1'b1;
    end
  end

  // one register write; valid is lowered after the handshake and sampled low before
  // the task returns, so back-to-back writes never raise and lower valid in the same step
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    do @(posedge clk_i); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // new geometry, sometimes with junk in the unused upper data bits and an
  // ignored write to an index past the register map
  task automatic frame_setup(input int unsigned w, input int unsigned h);
    logic [CFG_DATA_W-1:0] junk;
    junk = ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom) : '0;
    write_reg(REG_IMAGE_WIDTH, {junk[CFG_DATA_W-1:CFG_WIDTH_W], CFG_WIDTH_W'(w)});
    junk = ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom) : '0;
    write_reg(REG_IMAGE_HEIGHT, {junk[CFG_DATA_W-1:CFG_HEIGHT_W], CFG_HEIGHT_W'(h)});
    if ($urandom_range(0, 3) == 0) begin
      write_reg(CFG_IDX_W'($urandom_range(2, 255)), CFG_DATA_W'($urandom));
    end
  endtask

  // one pixel transfer, optionally preceded by a sender gap; valid stays high
  // afterwards so consecutive pixels can go back to back
  task automatic send_pixel(input pixel_t px);
    if (send_odds != 0 && $urandom_range(1, send_odds) == 1) begin
      pix_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    pix_bus.valid    <= 1'b1;
    pix_bus.in_red   <= px.red;
    pix_bus.in_green <= px.green;
    pix_bus.in_blue  <= px.blue;
    do @(posedge clk_i); while (!pix_bus.ready);
  endtask

  // stop sending until every expected result is back, then let the pipe settle
  task automatic hold_until_empty();
    pix_bus.valid <= 1'b0;
    do @(posedge clk_i); while (pending_cnt != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // mostly uniform, with black and white pixels often enough to hit both clamps
  function automatic pixel_t random_pixel();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return pixel_t'($urandom);
    endcase
  endfunction

  // 4x4 test frame: row 2 minus row 0 saturates high in red, stays in range in
  // green; row 3 minus row 1 saturates low in blue
  function automatic pixel_t ramp_pixel(input int x, input int y);
    case (y)
      0:       return '0;
      1:       return {8'd255, 8'd1, 8'd128};
      2:       return {8'd255, 8'(x * 20), 8'h80};
      default: return {8'd0, 8'd0, 8'(x)};
    endcase
  endfunction

  function automatic int unsigned pick_odds();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 3;
      2:       return 6;
      default: return 12;
    endcase
  endfunction

  initial begin
    int unsigned w;
    int unsigned h;
    int unsigned eff_w;
    int unsigned eff_h;
    int unsigned n;
    int unsigned split;

    cfg_bus.valid    = 1'b0;
    cfg_bus.index    = '0;
    cfg_bus.data     = '0;
    pix_bus.valid    = 1'b0;
    pix_bus.in_red   = '0;
    pix_bus.in_green = '0;
    pix_bus.in_blue  = '0;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: a few pixels under the reset geometry, all on the top border
    send_odds  = 6;
    stall_odds = 6;
    repeat (5) send_pixel(random_pixel());
    hold_until_empty();

    // 4x4 frame with both clamps, pausing mid-frame until the pipe is empty
    write_reg(REG_IMAGE_WIDTH, 16'd4);
    write_reg(REG_IMAGE_HEIGHT, 16'd4);
    for (int y = 0; y < 4; y++) begin
      for (int x = 0; x < 4; x++) begin
        if (y == 2 && x == 0) hold_until_empty();
        send_pixel(ramp_pixel(x, y));
      end
    end
    hold_until_empty();

    // 2x2 frame: every pixel is border, no interior result at all
    write_reg(REG_IMAGE_WIDTH, 16'd2);
    write_reg(REG_IMAGE_HEIGHT, 16'd2);
    send_pixel('1);
    send_pixel('0);
    send_pixel(random_pixel());
    send_pixel(random_pixel());
    hold_until_empty();

    // widest frame: width field all ones saturates to the line store size,
    // one row so frame_done lands on the last column
    send_odds  = 12;
    stall_odds = 12;
    write_reg(REG_IMAGE_WIDTH, '1);
    write_reg(REG_IMAGE_HEIGHT, 16'd1);
    repeat (MAX_WIDTH + 1) send_pixel(random_pixel());
    hold_until_empty();

    // tall frame: zero width reads as one, height field all ones saturates;
    // only the first rows of the single column, cut short by the next write
    write_reg(REG_IMAGE_WIDTH, 16'd0);
    write_reg(REG_IMAGE_HEIGHT, '1);
    repeat (30) send_pixel(random_pixel());
    hold_until_empty();

    // random frames of small sizes, whole frames mostly, some cut short by the
    // next register write and some running into a following frame
    while (random_items < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0:       w = 0;
        1:       w = 1;
        2:       w = 2;
        default: w = $urandom_range(3, 16);
      endcase
      case ($urandom_range(0, 9))
        0:       h = 0;
        1:       h = 1;
        2:       h = 2;
        default: h = $urandom_range(3, 10);
      endcase
      eff_w = (w == 0) ? 1 : w;
      eff_h = (h == 0) ? 1 : h;
      frame_setup(w, h);

      n = eff_w * eff_h * $urandom_range(1, 2);
      case ($urandom_range(0, 3))
        0:       n = n + $urandom_range(1, eff_w * eff_h);
        1:       n = $urandom_range(1, n);
        default: ;
      endcase
      // keep the total close to the item budget
      if (n > RANDOM_ITEMS - random_items) n = RANDOM_ITEMS - random_items;

      if (random_items + n >= RANDOM_ITEMS - QUIET_ITEMS) begin
        send_odds  = 0;
        stall_odds = 0;
      end else begin
        send_odds  = pick_odds();
        stall_odds = pick_odds();
      end

      // now and then stop mid-frame until every result is back
      split = ($urandom_range(0, 7) == 0) ? $urandom_range(1, n) : n;
      for (int i = 0; i < n; i++) begin
        if (i == split) hold_until_empty();
        send_pixel(random_pixel());
      end
      random_items += n;
      hold_until_empty();
    end

    if (mismatch_cnt == 0 && pending_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
